// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream find-and-replace package
// Shared types and constants: register indexes, configuration bundle and the
// result slot that carries one input's worth of output bytes.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Most output bytes that one input transfer can cause.
   localparam int MAX_RESULTS = 8;
   localparam int RES_CNT_W   = 4;
   localparam int RES_IDX_W   = 3;

   // Configuration port geometry: 64-bit registers at byte address 8*i.
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [63:0] replacement_bytes;
      logic [3:0]  replacement_length;
   } cfg_type;

   // One input's list of output bytes, oldest in entry zero.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [RES_CNT_W-1:0]        count;
      logic                        fin;
      logic                        has_byte;
   } slot_type;

endpackage

// ===== hw/rtl/sfr_csr.sv =====
// ----------------------------------------------------------------------------
// Stream find-and-replace configuration registers
// APB-style register file holding the pattern and the replacement text.
// ----------------------------------------------------------------------------
module sfr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output sfr_pkg::cfg_type                cfg
);
   import sfr_pkg::*;

   logic [63:0]   pattern_bytes_ff, pattern_bytes_in;
   logic [3:0]    pattern_length_ff, pattern_length_in;
   logic [63:0]   replacement_bytes_ff, replacement_bytes_in;
   logic [3:0]    replacement_length_ff, replacement_length_in;
   logic          write_en;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[4:3]);

   // Register write decode.
   always_comb begin
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      if (write_en) begin
         case (reg_index)
            REG_PATTERN_BYTES:      pattern_bytes_in      = csr_pwdata;
            REG_PATTERN_LENGTH:     pattern_length_in     = csr_pwdata[3:0];
            REG_REPLACEMENT_BYTES:  replacement_bytes_in  = csr_pwdata;
            REG_REPLACEMENT_LENGTH: replacement_length_in = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= 64'h0;
         pattern_length_ff     <= 4'd1;
         replacement_bytes_ff  <= 64'h0;
         replacement_length_ff <= 4'd0;
      end else begin
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
      end
   end

   // Read back of the addressed register.
   always_comb begin
      case (reg_index)
         REG_PATTERN_BYTES:      csr_prdata = pattern_bytes_ff;
         REG_PATTERN_LENGTH:     csr_prdata = CSR_DATA_W'(pattern_length_ff);
         REG_REPLACEMENT_BYTES:  csr_prdata = replacement_bytes_ff;
         REG_REPLACEMENT_LENGTH: csr_prdata = CSR_DATA_W'(replacement_length_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.pattern_bytes      = pattern_bytes_ff;
   assign cfg.pattern_length     = pattern_length_ff;
   assign cfg.replacement_bytes  = replacement_bytes_ff;
   assign cfg.replacement_length = replacement_length_ff;

endmodule

// ===== hw/rtl/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// Stream find-and-replace window cell
// Holds one held-back text byte and checks it against the pattern for every
// candidate alignment, narrowing the alive vector passed down the row.
// ----------------------------------------------------------------------------
module sfr_cell #(
   parameter int N = 8,
   parameter int K = 0
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [7:0]                   next_byte,
   input  logic [7:0]                   in_byte,
   input  logic [$clog2(N+1)-1:0]       pend_cnt,
   input  logic [63:0]                  pattern_bytes,
   input  logic [3:0]                   plen,
   input  logic [N-1:0]                 alive_in,
   output logic [N-1:0]                 alive_out,
   output logic [7:0]                   text_byte
);
   localparam int CW = $clog2(N+1);

   logic [7:0] byte_ff, byte_in;
   logic       valid;

   // Below the held count this cell shows its stored byte, at the count the
   // incoming byte, beyond it nothing.
   assign valid     = (pend_cnt >= CW'(K));
   assign text_byte = (CW'(K) < pend_cnt) ? byte_ff : in_byte;

   // Alignment s places this cell at pattern position K - s.
   always_comb begin
      int j;
      j = 0;
      for (int s = 0; s < N; s++) begin
         if (!valid || s > K) begin
            alive_out[s] = alive_in[s];
         end else begin
            j = K - s;
            alive_out[s] = alive_in[s] & (4'(j) < plen)
                           & (text_byte == pattern_bytes[8*j +: 8]);
         end
      end
   end

   // Byte shifted in from the window on each accepted transfer.
   assign byte_in = load ? next_byte : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ===== hw/rtl/sfr_out_queue.sv =====
// ----------------------------------------------------------------------------
// Stream find-and-replace output queue
// Two result slots: one being serialized onto the result stream one byte per
// transfer, one staged behind it so the input side keeps moving.
// ----------------------------------------------------------------------------
module sfr_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfr_pkg::slot_type push_slot,
   output logic              can_accept,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // out_byte
   output logic              rsp_tlast,   // run_last
   output logic [1:0]        rsp_tuser    // bit 0 has_byte, bit 1 stream_end
);
   import sfr_pkg::*;

   slot_type               s_slot_ff, s_slot_in;
   slot_type               t_slot_ff, t_slot_in;
   logic                   s_valid_ff, s_valid_in;
   logic                   t_valid_ff, t_valid_in;
   logic [RES_IDX_W-1:0]   idx_ff, idx_in;
   logic                   s_last;
   logic                   s_done;
   logic                   s_free;

   assign s_last = ({1'b0, idx_ff} == s_slot_ff.count - RES_CNT_W'(1));
   assign s_done = s_valid_ff & rsp_tready & s_last;
   assign s_free = ~s_valid_ff | s_done;

   assign can_accept = ~t_valid_ff;

   // Slot movement: the staged slot is older than a new push.
   always_comb begin
      s_slot_in  = s_slot_ff;
      t_slot_in  = t_slot_ff;
      s_valid_in = s_valid_ff;
      t_valid_in = t_valid_ff;
      idx_in     = idx_ff;
      if (s_free) begin
         idx_in = '0;
         if (t_valid_ff) begin
            s_slot_in  = t_slot_ff;
            s_valid_in = 1'b1;
            if (push) begin
               t_slot_in = push_slot;
            end else begin
               t_valid_in = 1'b0;
            end
         end else if (push) begin
            s_slot_in  = push_slot;
            s_valid_in = 1'b1;
         end else begin
            s_valid_in = 1'b0;
         end
      end else begin
         if (rsp_tready) begin
            idx_in = idx_ff + RES_IDX_W'(1);
         end
         if (push) begin
            t_slot_in  = push_slot;
            t_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         s_valid_ff <= s_valid_in;
         t_valid_ff <= t_valid_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      s_slot_ff <= s_slot_in;
      t_slot_ff <= t_slot_in;
   end

   // Result stream outputs.
   assign rsp_tvalid   = s_valid_ff;
   assign rsp_tdata    = s_slot_ff.bytes[idx_ff];
   assign rsp_tlast    = s_last;
   assign rsp_tuser[0] = s_slot_ff.has_byte;
   assign rsp_tuser[1] = s_last & s_slot_ff.fin;

   // A slot is staged only while the serializer holds one.
   a_staged_needs_active: assert property (@(posedge clock) disable iff (reset)
      t_valid_ff |-> s_valid_ff)
      else $error("staged result slot without an active slot");

   // The input side never pushes into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> ~t_valid_ff)
      else $error("result slot pushed while the queue is full");

   // An active slot carries one to eight results.
   a_slot_count: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> (s_slot_ff.count != '0)
                     && (s_slot_ff.count <= RES_CNT_W'(MAX_RESULTS)))
      else $error("active result slot has a bad count");

   // The serializer index stays inside the active slot.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> ({1'b0, idx_ff} < s_slot_ff.count))
      else $error("result index beyond the slot count");

endmodule

// ===== hw/rtl/stream_find_and_replace.sv =====
// ----------------------------------------------------------------------------
// Stream find-and-replace
// Replaces each leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement text, holding back bytes that may begin a match.
// ----------------------------------------------------------------------------
// The results of an input transfer are registered in the output queue. Throughput:
// one input per cycle while each input causes at most one result and the result
// side is ready; an input with k results holds the one-byte result port for k
// transfers, and two result slots of queueing decouple input from result side.
// Reset clears the held count, the queue and the registers; held bytes are
// left as they are and never read before being written.
module stream_find_and_replace #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // in_byte
   input  logic                            req_tlast,   // in_final
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // out_byte
   output logic                            rsp_tlast,   // run_last
   output logic [1:0]                      rsp_tuser,   // bit 0 has_byte, bit 1 stream_end
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import sfr_pkg::*;

   localparam int N  = PATTERN_MAX;
   localparam int CW = $clog2(N+1);

   cfg_type             cfg;
   slot_type            slot;
   logic                accept;
   logic                push;
   logic                can_accept;
   logic [CW-1:0]       pend_cnt_ff, pend_cnt_in;
   logic [N:0][N-1:0]   alive;
   logic [N-1:0][7:0]   text_bytes;
   logic [N-1:0][7:0]   next_bytes;
   logic [3:0]          plen;
   logic [3:0]          rlen;
   logic [CW-1:0]       total;
   logic [CW-1:0]       shift;
   logic [CW-1:0]       remain;
   logic                match;
   logic [4:0]          rep_total;

   // Configuration registers.
   sfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Effective lengths: pattern clamped to one..PATTERN_MAX, replacement to
   // at most REPLACE_MAX.
   always_comb begin
      plen = cfg.pattern_length;
      if (plen == 4'd0) begin
         plen = 4'd1;
      end
      if (plen > 4'(PATTERN_MAX)) begin
         plen = 4'(PATTERN_MAX);
      end
      rlen = cfg.replacement_length;
      if (rlen > 4'(REPLACE_MAX)) begin
         rlen = 4'(REPLACE_MAX);
      end
   end

   assign accept = req_tvalid & req_tready;
   assign total  = pend_cnt_ff + CW'(1);

   // Row of window cells; the alive vector flows from the oldest byte on.
   assign alive[0] = '1;

   for (genvar k = 0; k < N; k++) begin : g_cell
      sfr_cell #(
         .N (N),
         .K (k)
      ) u_cell (
         .clock         (clock),
         .load          (accept),
         .next_byte     (next_bytes[k]),
         .in_byte       (req_tdata),
         .pend_cnt      (pend_cnt_ff),
         .pattern_bytes (cfg.pattern_bytes),
         .plen          (plen),
         .alive_in      (alive[k]),
         .alive_out     (alive[k+1]),
         .text_byte     (text_bytes[k])
      );
   end

   // Smallest alignment whose tail is still a pattern prefix; none releases
   // the whole window.
   always_comb begin
      shift = total;
      for (int s = N - 1; s >= 0; s--) begin
         if ((CW'(s) < total) && alive[N][s]) begin
            shift = CW'(s);
         end
      end
   end

   assign remain    = total - shift;
   assign match     = (shift != total) && (4'(remain) == plen);
   assign rep_total = 5'(shift) + 5'(rlen);

   // Result list: released bytes, then the replacement or the flushed tail.
   always_comb begin
      slot.fin      = req_tlast;
      slot.has_byte = 1'b1;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot.bytes[i] = 8'h00;
         if (match && (i >= int'(shift))) begin
            slot.bytes[i] = cfg.replacement_bytes[8*(i - int'(shift)) +: 8];
         end else if (i < N) begin
            slot.bytes[i] = text_bytes[i];
         end
      end
      if (match) begin
         slot.count = (rep_total > 5'(MAX_RESULTS)) ? RES_CNT_W'(MAX_RESULTS)
                                                    : RES_CNT_W'(rep_total);
      end else if (req_tlast) begin
         slot.count = RES_CNT_W'(total);
      end else begin
         slot.count = RES_CNT_W'(shift);
      end
      // A final byte with nothing due still ends the stream with a marker.
      if ((slot.count == '0) && req_tlast) begin
         slot.count    = RES_CNT_W'(1);
         slot.has_byte = 1'b0;
         slot.bytes[0] = 8'h00;
      end
   end

   assign push = accept && (slot.count != '0);

   // Held window after this transfer: the tail from the alignment on.
   always_comb begin
      int idx;
      for (int k = 0; k < N; k++) begin
         idx = k + int'(shift);
         next_bytes[k] = (idx < N) ? text_bytes[idx] : 8'h00;
      end
      pend_cnt_in = pend_cnt_ff;
      if (accept) begin
         pend_cnt_in = (match || req_tlast) ? '0 : remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= '0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   // Result queue and serializer.
   sfr_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_slot  (slot),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = can_accept;

endmodule

// ===== verif/stream_find_and_replace_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find-and-replace testbench
// Drives byte streams with random gaps and end-of-stream marks into the block.
// It sets pattern and replacement registers between phases and predicts every
// output byte, end-of-run flag and end-of-stream flag. Each accepted result
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module stream_find_and_replace_test;
   import sfr_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 42;
   localparam int LONG_HOLD     = 400;
   localparam int WATCHDOG_NS   = 4_000_000;

   // Eight-byte pattern used for the deepest fallback and the mid-stream change.
   localparam logic [63:0] DEEP_PATTERN = 64'h0102_0304_0506_0780;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       stream_end;
   } text_result_type;

   typedef struct packed {
      logic       fin;
      logic [7:0] text;
   } text_item_type;

   // Tracks the held bytes and registers, and holds the results still due.
   class replace_scoreboard;
      logic [63:0]     pattern_word;
      logic [3:0]      pattern_len;
      logic [63:0]     replace_word;
      logic [3:0]      replace_len;
      logic [7:0]      held [7];
      int unsigned     held_count;
      text_result_type step_q [$];
      text_result_type due_q [$];
      int unsigned     errors;

      function new();
         pattern_word = '0;
         pattern_len  = 4'd1;
         replace_word = '0;
         replace_len  = 4'd0;
         held_count   = 0;
         errors       = 0;
      endfunction

      function void write_register(reg_index_type index, logic [63:0] value);
         case (index)
            REG_PATTERN_BYTES:      pattern_word = value;
            REG_PATTERN_LENGTH:     pattern_len  = value[3:0];
            REG_REPLACEMENT_BYTES:  replace_word = value;
            REG_REPLACEMENT_LENGTH: replace_len  = value[3:0];
            default: ;
         endcase
      endfunction

      // One input transfer never causes more than MAX_RESULTS results.
      function void emit_text(logic [7:0] value, logic has);
         text_result_type r;
         if (step_q.size() >= MAX_RESULTS) return;
         r.out_byte   = has ? value : 8'd0;
         r.has_byte   = has;
         r.run_last   = 1'b0;
         r.stream_end = 1'b0;
         step_q.push_back(r);
      endfunction

      function void take_input(logic [7:0] in_byte, logic in_final);
         logic [7:0]  work [8];
         int unsigned fill;
         int unsigned plen;
         int unsigned rlen;
         int unsigned i;
         bit          leads;
         plen = (pattern_len == 4'd0) ? 1 : (pattern_len > 4'd8) ? 8 : int'(pattern_len);
         rlen = (replace_len > 4'd8) ? 8 : int'(replace_len);
         step_q.delete();
         for (i = 0; i < held_count; i++) work[i] = held[i];
         work[held_count] = in_byte;
         fill = held_count + 1;

         // Release the oldest byte until the rest leads into the pattern.
         while (fill > 0) begin
            leads = (fill <= plen);
            for (i = 0; i < fill && leads; i++) begin
               if (work[i] != pattern_word[8*i +: 8]) leads = 1'b0;
            end
            if (leads) begin
               if (fill == plen) begin
                  for (i = 0; i < rlen; i++) emit_text(replace_word[8*i +: 8], 1'b1);
                  fill = 0;
               end
               break;
            end
            emit_text(work[0], 1'b1);
            for (i = 1; i < fill; i++) work[i-1] = work[i];
            fill--;
         end

         // The end of the stream flushes whatever is still held.
         if (in_final) begin
            for (i = 0; i < fill; i++) emit_text(work[i], 1'b1);
            fill = 0;
         end
         for (i = 0; i < fill; i++) held[i] = work[i];
         held_count = fill;

         // A final byte with nothing due still closes the stream with a marker.
         if (step_q.size() == 0 && in_final) emit_text(8'd0, 1'b0);
         if (step_q.size() > 0) begin
            step_q[step_q.size()-1].run_last   = 1'b1;
            step_q[step_q.size()-1].stream_end = in_final;
         end
         foreach (step_q[k]) due_q.push_back(step_q[k]);
      endfunction

      function void check_output(logic [7:0] data, logic last, logic [1:0] user);
         text_result_type want;
         if (due_q.size() == 0) begin
            $error("result with nothing expected: out_byte %h, run_last %b, tuser %b",
                   data, last, user);
            errors++;
            return;
         end
         want = due_q.pop_front();
         if (data !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, data);
            errors++;
         end
         if (user[0] !== want.has_byte) begin
            $error("has_byte: expected %b, got %b", want.has_byte, user[0]);
            errors++;
         end
         if (last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, last);
            errors++;
         end
         if (user[1] !== want.stream_end) begin
            $error("stream_end: expected %b, got %b", want.stream_end, user[1]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // in_byte
   logic                  req_tlast;   // in_final
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // out_byte
   logic                  rsp_tlast;   // run_last
   logic [1:0]            rsp_tuser;   // bit 0 has_byte, bit 1 stream_end
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   replace_scoreboard board = new();
   text_item_type     stream_q [$];
   bit                req_burst = 1'b0;
   bit                rsp_burst = 1'b0;
   int unsigned       rsp_hold  = 0;

   stream_find_and_replace uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Idle cycles before a transfer; each side now and then switches to a
   // stretch of back-to-back transfers.
   function automatic int unsigned draw_gap(ref bit burst);
      if ($urandom_range(0, 23) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic csr_write(reg_index_type index, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.write_register(index, value);
   endtask

   task automatic configure(logic [63:0] pat_word, logic [3:0] pat_len,
                            logic [63:0] rep_word, logic [3:0] rep_len);
      csr_write(REG_PATTERN_BYTES, pat_word);
      csr_write(REG_PATTERN_LENGTH, {60'd0, pat_len});
      csr_write(REG_REPLACEMENT_BYTES, rep_word);
      csr_write(REG_REPLACEMENT_LENGTH, {60'd0, rep_len});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(text_item_type item, bit eager);
      int unsigned gap;
      gap = eager ? 0 : draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item.text;
      req_tlast  <= item.fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.take_input(item.text, item.fin);
   endtask

   // Sends the queued text, then waits until every predicted result has come
   // and the block has had time to finish inputs that cause none.
   task automatic drive_stream(bit eager);
      while (stream_q.size() > 0) send_byte(stream_q.pop_front(), eager);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.due_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random registers, then text built mostly from whole and broken pattern
   // copies over a small alphabet so that partial matches happen often.
   task automatic run_random_phase(int unsigned count, bit eager);
      logic [7:0]  alphabet [3];
      logic [63:0] pat_word;
      logic [63:0] rep_word;
      logic [3:0]  pat_len;
      logic [3:0]  rep_len;
      int unsigned eff_len;
      int unsigned pick;
      int unsigned cut;
      int unsigned k;
      for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
      case ($urandom_range(0, 5))
         0:       pat_len = 4'($urandom_range(0, 15));
         1:       pat_len = 4'd8;
         2:       pat_len = 4'd1;
         default: pat_len = 4'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 4))
         0:       rep_len = 4'($urandom_range(0, 15));
         1:       rep_len = 4'd0;
         2:       rep_len = 4'd8;
         default: rep_len = 4'($urandom_range(1, 8));
      endcase
      pat_word = {$urandom, $urandom};
      for (k = 0; k < 8; k++) begin
         if ($urandom_range(0, 7) != 0) pat_word[8*k +: 8] = alphabet[$urandom_range(0, 2)];
      end
      rep_word = {$urandom, $urandom};
      eff_len  = (pat_len == 4'd0) ? 1 : (pat_len > 4'd8) ? 8 : int'(pat_len);
      configure(pat_word, pat_len, rep_word, rep_len);

      while (stream_q.size() < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) cut = eff_len;
         else if (pick < 6) cut = $urandom_range(1, eff_len);
         else cut = 0;
         for (k = 0; k < cut; k++) begin
            stream_q.push_back(text_item_type'{($urandom_range(0, 23) == 0),
                                               pat_word[8*k +: 8]});
         end
         if (cut == 0) begin
            stream_q.push_back(text_item_type'{($urandom_range(0, 23) == 0),
               (pick < 9) ? alphabet[$urandom_range(0, 2)] : 8'($urandom)});
         end
      end
      drive_stream(eager);
   endtask

   // Result side: random readiness, and one long hold-off when asked.
   initial begin : result_sink
      int unsigned gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = draw_gap(rsp_burst);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         board.check_output(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   initial begin : main_sequence
      int unsigned phase;
      int unsigned k;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two-byte pattern: matches, a false start, byte extremes, flush at end.
      configure(64'hFFFF_FFFF_FFFF_6261, 4'd2, 64'h0000_0000_005A_5958, 4'd3);
      stream_q.push_back(text_item_type'{1'b0, "a"});
      stream_q.push_back(text_item_type'{1'b0, "b"});
      stream_q.push_back(text_item_type'{1'b0, "a"});
      stream_q.push_back(text_item_type'{1'b0, "a"});
      stream_q.push_back(text_item_type'{1'b0, "b"});
      stream_q.push_back(text_item_type'{1'b0, 8'h00});
      stream_q.push_back(text_item_type'{1'b0, 8'hFF});
      stream_q.push_back(text_item_type'{1'b1, "a"});
      drive_stream(1'b0);

      // Zero pattern length acts as one; an empty replacement deletes, so a
      // final match leaves only the bare end marker.
      configure(64'h0000_0000_0000_00FF, 4'd0, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0);
      stream_q.push_back(text_item_type'{1'b1, 8'hFF});
      stream_q.push_back(text_item_type'{1'b0, 8'h00});
      stream_q.push_back(text_item_type'{1'b0, 8'hFF});
      stream_q.push_back(text_item_type'{1'b1, 8'h7F});
      drive_stream(1'b0);

      // Oversized lengths saturate to eight: a full match, then seven held bytes.
      configure(DEEP_PATTERN, 4'd15, 64'hF0E1_D2C3_B4A5_9687, 4'd12);
      for (k = 0; k < 8; k++) begin
         stream_q.push_back(text_item_type'{1'b0, DEEP_PATTERN[8*k +: 8]});
      end
      for (k = 0; k < 7; k++) begin
         stream_q.push_back(text_item_type'{1'b0, DEEP_PATTERN[8*k +: 8]});
      end
      drive_stream(1'b0);

      // New pattern while seven bytes are held: the released bytes and the
      // replacement overflow the eight results of one transfer.
      configure(64'h0000_0000_0000_0055, 4'd1, 64'h8877_6655_4433_2211, 4'd8);
      stream_q.push_back(text_item_type'{1'b1, 8'h55});
      drive_stream(1'b0);

      // Random phases; one of them fills the block behind a long result stall.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3) rsp_hold = LONG_HOLD;
         run_random_phase(PHASE_ITEMS, phase == 3);
      end

      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("FAILURE");
      $finish;
   end

endmodule
